// ----- hdl/ctpf_pkg.sv -----
// Shared constants and widths for the cyan tone pixel filter.
`timescale 1ns / 1ps

package ctpf_pkg;

    // Channel and arithmetic widths.
    localparam int CHAN_W   = 8;
    localparam int PCT_W    = 7;   // percentages run 0..100
    localparam int NUM_W    = 16;  // 200*diff + mx, at most 51255
    localparam int DEN_W    = 9;   // 2*mx, at most 510
    localparam int PROD_W   = 16;  // (255-cyan)*(255-k), at most 65025
    localparam int NUM2_W   = 17;  // 2*product + 255

    // Quotient bits resolved in each divider stage.
    localparam int DIV_STEPS = 2;

    // Fixed constants of the color math.
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [NUM_W-1:0]  PCT_TWICE  = 16'd200;
    localparam logic [NUM_W-1:0]  K_BIAS     = 16'd255;
    localparam logic [DEN_W-1:0]  FULL_TWICE = 9'd510;
    localparam logic [DEN_W-1:0]  BLACK_DEN  = 9'd2;
    localparam logic [NUM2_W-1:0] RED_BIAS   = 17'd255;

endpackage

// ----- hdl/cyan_tone_pixel_filter.sv -----
// Top level of the cyan tone pixel filter pipeline.
`timescale 1ns / 1ps

// The filter takes one RGB pixel per clock and never stalls: busy is tied low,
// so a request is accepted at every rising edge where start is high. Each pixel
// comes out with o_valid high for exactly one cycle; the receiver must take it
// then, since it cannot hold the result off. A pixel passes the input and
// numerator registers, the first of the two pipelined dividers, the multiply
// register and then the red divider; both dividers resolve two quotient bits per
// stage (four stages for the 7-bit percentages, four for the 8-bit red channel).
// Green and blue both carry 255 minus the black percentage; red is darkened by
// cyan only when cyan strictly dominates magenta and yellow. A black pixel
// yields 155 on all three channels.
module cyan_tone_pixel_filter
    import ctpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAN_W-1:0] i_in_red,
    input  logic [CHAN_W-1:0] i_in_green,
    input  logic [CHAN_W-1:0] i_in_blue,
    output logic              o_valid,
    output logic [CHAN_W-1:0] o_out_red,
    output logic [CHAN_W-1:0] o_out_green,
    output logic [CHAN_W-1:0] o_out_blue
);

    localparam int LAT2 = (CHAN_W + DIV_STEPS - 1) / DIV_STEPS;

    // Stage 0: registered input pixel.
    logic              r0_vld;
    logic [CHAN_W-1:0] r0_red;
    logic [CHAN_W-1:0] r0_green;
    logic [CHAN_W-1:0] r0_blue;

    // Stage 1: numerators for the four percentage divides, and the denominator of the cyan, magenta and yellow divides.
    logic              r1_vld;
    logic [NUM_W-1:0]  r1_num_c;
    logic [NUM_W-1:0]  r1_num_m;
    logic [NUM_W-1:0]  r1_num_y;
    logic [NUM_W-1:0]  r1_num_k;
    logic [DEN_W-1:0]  r1_den;

    logic [CHAN_W-1:0] n_mx;
    logic [NUM_W-1:0]  n_num_c;
    logic [NUM_W-1:0]  n_num_m;
    logic [NUM_W-1:0]  n_num_y;
    logic [NUM_W-1:0]  n_num_k;
    logic [DEN_W-1:0]  n_den;

    // Percentages out of the first divider bank.
    logic              w_pct_vld;
    logic [PCT_W-1:0]  w_c;
    logic [PCT_W-1:0]  w_m;
    logic [PCT_W-1:0]  w_y;
    logic [PCT_W-1:0]  w_k;

    // Stage 2: product feeding the red divide, and the green/blue value.
    logic              r2_vld;
    logic [PROD_W-1:0] r2_prod;
    logic [CHAN_W-1:0] r2_gb;
    logic [PCT_W-1:0]  n_cyan;
    logic [CHAN_W-1:0] n_gb;
    logic [CHAN_W-1:0] n_inv_cyan;

    logic [CHAN_W-1:0] r_gb_dly [LAT2];
    logic [NUM2_W-1:0] w_num_red;

    // The pipeline never holds a request back.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
        r0_red   <= i_in_red;
        r0_green <= i_in_green;
        r0_blue  <= i_in_blue;
    end

    // Each percentage is round(100*d/mx) = (200*d + mx) / (2*mx). With mx of
    // zero every difference is zero, so a denominator of two gives zero.
    always_comb begin
        n_mx = r0_red;
        if (r0_green > n_mx) begin
            n_mx = r0_green;
        end
        if (r0_blue > n_mx) begin
            n_mx = r0_blue;
        end
        n_num_c = NUM_W'(n_mx - r0_red) * PCT_TWICE + NUM_W'(n_mx);
        n_num_m = NUM_W'(n_mx - r0_green) * PCT_TWICE + NUM_W'(n_mx);
        n_num_y = NUM_W'(n_mx - r0_blue) * PCT_TWICE + NUM_W'(n_mx);
        n_num_k = NUM_W'(FULL_SCALE - n_mx) * PCT_TWICE + K_BIAS;
        n_den   = (n_mx == '0) ? BLACK_DEN : {n_mx, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_num_c <= n_num_c;
        r1_num_m <= n_num_m;
        r1_num_y <= n_num_y;
        r1_num_k <= n_num_k;
        r1_den   <= n_den;
    end

    ctpf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(PCT_W)) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   (r1_num_c),
        .i_den   (r1_den),
        .o_vld   (w_pct_vld),
        .o_quo   (w_c)
    );

    ctpf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(PCT_W)) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   (r1_num_m),
        .i_den   (r1_den),
        .o_vld   (),
        .o_quo   (w_m)
    );

    ctpf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(PCT_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   (r1_num_y),
        .i_den   (r1_den),
        .o_vld   (),
        .o_quo   (w_y)
    );

    // Black percentage: round(100*(255-mx)/255) = (200*(255-mx) + 255) / 510.
    ctpf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(PCT_W)) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   (r1_num_k),
        .i_den   (FULL_TWICE),
        .o_vld   (),
        .o_quo   (w_k)
    );

    // Cyan survives only when it is strictly larger than both other inks.
    always_comb begin
        n_cyan     = (w_c > w_m && w_c > w_y) ? w_c : '0;
        n_inv_cyan = FULL_SCALE - CHAN_W'(n_cyan);
        n_gb       = FULL_SCALE - CHAN_W'(w_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= w_pct_vld;
        end
        r2_prod <= PROD_W'(n_inv_cyan) * PROD_W'(n_gb);
        r2_gb   <= n_gb;
    end

    // Red is round(prod/255) = (2*prod + 255) / 510.
    assign w_num_red = {r2_prod, 1'b0} + RED_BIAS;

    ctpf_div #(.NUM_W(NUM2_W), .DEN_W(DEN_W), .Q_W(CHAN_W)) u_div_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_num   (w_num_red),
        .i_den   (FULL_TWICE),
        .o_vld   (o_valid),
        .o_quo   (o_out_red)
    );

    // Green and blue wait alongside the red divide.
    always_ff @(posedge i_clk) begin
        r_gb_dly[0] <= r2_gb;
        for (int i = 1; i < LAT2; i++) begin
            r_gb_dly[i] <= r_gb_dly[i-1];
        end
    end

    assign o_out_green = r_gb_dly[LAT2-1];
    assign o_out_blue  = r_gb_dly[LAT2-1];

endmodule

// ----- hdl/ctpf_div.sv -----
// Pipelined restoring divider that resolves a fixed number of quotient bits per stage.
`timescale 1ns / 1ps

module ctpf_div
    import ctpf_pkg::*;
#(
    parameter int NUM_W = 16,
    parameter int DEN_W = 9,
    parameter int Q_W   = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output logic [Q_W-1:0]   o_quo
);

    localparam int NSTG = (Q_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int CW   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [NSTG];
    logic [Q_W-1:0]   r_quo [NSTG];
    logic [DEN_W-1:0] r_den [NSTG];
    logic             r_vld [NSTG];

    // The caller guarantees that the quotient fits in Q_W bits.
    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in;
        logic [Q_W-1:0]   w_quo_in;
        logic [DEN_W-1:0] w_den_in;
        logic             w_vld_in;
        logic [NUM_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quo;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
            assign w_vld_in = i_vld;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_den_in = r_den[s-1];
            assign w_vld_in = r_vld[s-1];
        end

        always_comb begin
            logic [CW-1:0] dsh;
            int            bi;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                bi  = Q_W - 1 - (s * DIV_STEPS + j);
                dsh = CW'(w_den_in) << ((bi < 0) ? 0 : bi);
                if (bi >= 0 && CW'(n_rem) >= dsh) begin
                    n_rem = n_rem - dsh[NUM_W-1:0];
                    n_quo[(bi < 0) ? 0 : bi] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld_in;
            end
            r_rem[s] <= n_rem;
            r_quo[s] <= n_quo;
            r_den[s] <= w_den_in;
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_quo = r_quo[NSTG-1];

endmodule

// ----- sim/ctpf_checker.sv -----
// Scoreboard for the cyan tone pixel filter: predicts each toned pixel and checks the outputs.
`timescale 1ns / 1ps

module ctpf_checker
    import ctpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [CHAN_W-1:0] i_in_red,
    input  logic [CHAN_W-1:0] i_in_green,
    input  logic [CHAN_W-1:0] i_in_blue,
    input  logic              i_valid,
    input  logic [CHAN_W-1:0] i_out_red,
    input  logic [CHAN_W-1:0] i_out_green,
    input  logic [CHAN_W-1:0] i_out_blue,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int PRINT_CAP = 20;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel src;
        t_pixel toned;
    } t_toned_entry;

    t_toned_entry toned_q[$];
    t_toned_entry oldest;
    t_toned_entry fresh;
    int           pops;
    int           pushes;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Rational rounding, half up, for den > 0.
    function automatic int unsigned half_up_div(input int unsigned num, input int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic int unsigned channel_pct(input int unsigned mx, input int unsigned ch);
        if (mx == 0) begin
            return 0;
        end
        return half_up_div(100 * (mx - ch), mx);
    endfunction

    function automatic t_pixel tone_pixel(input t_pixel px);
        int unsigned mx;
        int unsigned k;
        int unsigned c;
        int unsigned m;
        int unsigned y;
        int unsigned cyan;
        t_pixel      res;
        mx = 32'(px.red);
        if (32'(px.green) > mx) begin
            mx = 32'(px.green);
        end
        if (32'(px.blue) > mx) begin
            mx = 32'(px.blue);
        end
        k    = half_up_div(100 * (255 - mx), 255);
        c    = channel_pct(mx, 32'(px.red));
        m    = channel_pct(mx, 32'(px.green));
        y    = channel_pct(mx, 32'(px.blue));
        cyan = (c > m && c > y) ? c : 0;
        res.red   = CHAN_W'(half_up_div((255 - cyan) * (255 - k), 255));
        res.green = CHAN_W'(255 - k);
        res.blue  = CHAN_W'(255 - k);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (o_fail_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        pops   = 0;
        pushes = 0;
        if (i_rst_n) begin
            if (i_valid) begin
                if (toned_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no request pending",
                                              i_out_red, i_out_green, i_out_blue));
                end else begin
                    oldest = toned_q.pop_front();
                    pops   = 1;
                    if (i_out_red !== oldest.toned.red) begin
                        report_mismatch($sformatf("red %0h expected %0h for in %0d/%0d/%0d",
                                                  i_out_red, oldest.toned.red, oldest.src.red,
                                                  oldest.src.green, oldest.src.blue));
                    end
                    if (i_out_green !== oldest.toned.green) begin
                        report_mismatch($sformatf("green %0h expected %0h for in %0d/%0d/%0d",
                                                  i_out_green, oldest.toned.green, oldest.src.red,
                                                  oldest.src.green, oldest.src.blue));
                    end
                    if (i_out_blue !== oldest.toned.blue) begin
                        report_mismatch($sformatf("blue %0h expected %0h for in %0d/%0d/%0d",
                                                  i_out_blue, oldest.toned.blue, oldest.src.red,
                                                  oldest.src.green, oldest.src.blue));
                    end
                end
            end
            if (i_start && !i_busy) begin
                fresh.src.red   = i_in_red;
                fresh.src.green = i_in_green;
                fresh.src.blue  = i_in_blue;
                fresh.toned     = tone_pixel(fresh.src);
                toned_q.push_back(fresh);
                pushes = 1;
            end
        end
        o_pending <= o_pending + pushes - pops;
    end

endmodule

// ----- sim/tb_cyan_tone_pixel_filter.sv -----
// Testbench top for the cyan tone pixel filter: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 1ps

// The top only produces requests and decides the outcome. All prediction and
// comparison lives in the checker, which sits beside the filter, sees every
// accepted request and every result strobe, and hands back a mismatch count
// together with the number of results still owed by the filter.
module tb_cyan_tone_pixel_filter
    import ctpf_pkg::*;
();

    // LATENCY stands for the filter's answer delay; the tail wait is derived from
    // it with some margin, while the drain limit is set on its own.
    localparam int LATENCY     = 11;
    localparam int DRAIN_LIMIT = 1000;
    localparam int IDLE_PCT    = 37;
    localparam int RANDOM_ITEMS = 900;
    // Pause for every outstanding result once in a while.
    localparam int PAUSE_EVERY = 150;
    // Random items in this window are sent back to back with no idling.
    localparam int BURST_FIRST = 300;
    localparam int BURST_LAST  = 549;

    typedef enum int {
        MIX_ANY,
        MIX_CYAN_LEADS,
        MIX_TIE,
        MIX_DARK,
        MIX_ONE_FULL,
        MIX_GRAY
    } t_pixel_mix;

    logic              clk    = 1'b0;
    logic              rst_n  = 1'b0;
    logic              start  = 1'b0;
    logic [CHAN_W-1:0] red_in   = '0;
    logic [CHAN_W-1:0] green_in = '0;
    logic [CHAN_W-1:0] blue_in  = '0;
    logic              busy;
    logic              valid;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;

    int fail_count;
    int pending;
    int drain_errors = 0;
    int pixels_sent  = 0;
    int directed_cnt = 0;
    int pauses       = 0;
    bit idle_on      = 1'b1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cyan_tone_pixel_filter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_red    (red_in),
        .i_in_green  (green_in),
        .i_in_blue   (blue_in),
        .o_valid     (valid),
        .o_out_red   (red_out),
        .o_out_green (green_out),
        .o_out_blue  (blue_out)
    );

    ctpf_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in_red     (red_in),
        .i_in_green   (green_in),
        .i_in_blue    (blue_in),
        .i_valid      (valid),
        .i_out_red    (red_out),
        .i_out_green  (green_out),
        .i_out_blue   (blue_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Send one pixel request. Idle cycles may come first; during them start is
    // low and the channel inputs carry junk that must be ignored. The request
    // is held until an edge sees busy low. Only one nonblocking write to start
    // happens per time step, so a back-to-back request keeps start high.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            start    <= 1'b0;
            red_in   <= CHAN_W'($urandom);
            green_in <= CHAN_W'($urandom);
            blue_in  <= CHAN_W'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    // Stop sending and wait until the filter has delivered every result. The
    // first edge lets the checker count the last accepted request.
    task automatic drain_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        if (pending != 0) begin
            $display("[%0t] %0d results never arrived", $realtime, pending);
            drain_errors++;
        end
        pauses++;
    endtask

    // Build one random pixel. Most of the mixes steer toward the interesting
    // parts of the math: cyan clearly leading, exact ties that must kill cyan,
    // very dark pixels where the percentages are coarse, and saturated or gray
    // pixels at the edges of the black percentage.
    task automatic pick_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
                              output logic [CHAN_W-1:0] b);
        t_pixel_mix  mix;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] lo;
        mix = t_pixel_mix'($urandom_range(0, 5));
        r   = CHAN_W'($urandom);
        g   = CHAN_W'($urandom);
        b   = CHAN_W'($urandom);
        case (mix)
            MIX_CYAN_LEADS: begin
                hi = CHAN_W'($urandom_range(1, 255));
                lo = CHAN_W'($urandom_range(0, hi));
                r  = lo;
                g  = CHAN_W'($urandom_range(lo, hi));
                b  = CHAN_W'($urandom_range(lo, hi));
                if ($urandom_range(0, 1) == 0) begin
                    g = hi;
                end else begin
                    b = hi;
                end
            end
            MIX_TIE: begin
                if ($urandom_range(0, 1) == 0) begin
                    g = r;
                end else begin
                    b = r;
                end
            end
            MIX_DARK: begin
                r = CHAN_W'($urandom_range(0, 3));
                g = CHAN_W'($urandom_range(0, 3));
                b = CHAN_W'($urandom_range(0, 3));
            end
            MIX_ONE_FULL: begin
                case ($urandom_range(0, 2))
                    0: r = FULL_SCALE;
                    1: g = FULL_SCALE;
                    default: b = FULL_SCALE;
                endcase
            end
            MIX_GRAY: begin
                g = r;
                b = r;
            end
            default: begin
            end
        endcase
    endtask

    // Directed corners: black, white, primaries and secondaries, the two kinds
    // of tie, a pixel where cyan wins, near-black and near-white values.
    localparam int DIRECTED_N = 20;
    logic [3*CHAN_W-1:0] corner_px [DIRECTED_N] = '{
        {8'd0,   8'd0,   8'd0},
        {8'd255, 8'd255, 8'd255},
        {8'd255, 8'd0,   8'd0},
        {8'd0,   8'd255, 8'd0},
        {8'd0,   8'd0,   8'd255},
        {8'd255, 8'd255, 8'd0},
        {8'd255, 8'd0,   8'd255},
        {8'd0,   8'd255, 8'd255},
        {8'd10,  8'd10,  8'd200},
        {8'd10,  8'd200, 8'd10},
        {8'd10,  8'd200, 8'd150},
        {8'd0,   8'd128, 8'd255},
        {8'd1,   8'd0,   8'd0},
        {8'd0,   8'd0,   8'd1},
        {8'd1,   8'd1,   8'd1},
        {8'd0,   8'd1,   8'd1},
        {8'd128, 8'd128, 8'd128},
        {8'd127, 8'd64,  8'd200},
        {8'd254, 8'd253, 8'd252},
        {8'd170, 8'd85,  8'd255}
    };

    initial begin
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
            if (i == DIRECTED_N / 2) begin
                drain_results();
            end
        end
        directed_cnt = DIRECTED_N;
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = !(i >= BURST_FIRST && i <= BURST_LAST);
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
            if (i % PAUSE_EVERY == PAUSE_EVERY - 1) begin
                drain_results();
            end
        end

        // Final drain, then a further wait derived from LATENCY in case a stray strobe follows.
        drain_results();
        repeat (LATENCY + 5) @(posedge clk);

        $display("summary: %0d pixels (%0d directed corners, rest random with ties, dark,",
                 pixels_sent, directed_cnt);
        $display("summary: saturated, gray and cyan-leading mixes), %0d full drains",
                 pauses);
        if (fail_count == 0 && drain_errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- cyan_tone_pixel_filter.f -----
hdl/ctpf_pkg.sv
hdl/ctpf_div.sv
hdl/cyan_tone_pixel_filter.sv
sim/ctpf_checker.sv
sim/tb_cyan_tone_pixel_filter.sv
